// File: src/bmfc_pkg.sv
// ----------------------------------------------------------------------------
// Block matched-filter convolver package
// Shared widths, constants, register indexes and the queued item type.
// ----------------------------------------------------------------------------
`default_nettype none

package bmfc_pkg;

  localparam int MAX_BLOCK   = 2048;
  localparam int MAX_KERNEL  = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int BLK_W  = 12;
  localparam int KER_W  = 7;
  localparam int TAP_W  = $clog2(MAX_KERNEL);
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = 38;
  localparam int CFG_W  = 12;
  localparam int CFG_IDX_W = 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LENGTH = 1'b1;

  localparam logic [BLK_W-1:0] BLOCK_LENGTH_RST  = BLK_W'(MAX_BLOCK);
  localparam logic [KER_W-1:0] KERNEL_LENGTH_RST = KER_W'(MAX_KERNEL);

  typedef struct packed {
    logic                          is_sample;
    logic [TAP_W-1:0]              idx;
    logic signed [SAMPLE_BITS-1:0] value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

`default_nettype wire

// File: src/bmfc_front.sv
// ----------------------------------------------------------------------------
// Front end: input acceptance and item queue
// Accepts input transfers, tags each as coefficient or sample and holds them
// in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module bmfc_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_kind,
  input  wire logic [bmfc_pkg::TAP_W-1:0]             in_coef_index,
  input  wire logic signed [bmfc_pkg::SAMPLE_BITS-1:0] in_value,
  output bmfc_pkg::queue_head_t                       head,
  input  wire logic                                   pop
);
  import bmfc_pkg::*;

  item_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              do_pop;
  item_t             new_item;

  assign in_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (cnt_r != '0);

  always_comb begin
    new_item.is_sample = (in_kind == KIND_SAMPLE);
    new_item.idx       = in_coef_index;
    new_item.value     = in_value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_comb begin
    head.valid = (cnt_r != '0);
    head.item  = q_mem[rd_ptr_r];
  end

endmodule

`default_nettype wire

// File: src/bmfc_back.sv
// ----------------------------------------------------------------------------
// Back end: coefficient store, delay line and shared multiply-accumulate
// Applies coefficient writes, appends samples to a circular delay line and
// walks the taps of each convolution output through one pipelined MAC.
// ----------------------------------------------------------------------------
`default_nettype none

module bmfc_back (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cfg_we,
  input  wire logic [bmfc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [bmfc_pkg::CFG_W-1:0]              cfg_data,
  input  wire bmfc_pkg::queue_head_t                   head,
  output logic                                         pop,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [bmfc_pkg::ACC_W-1:0]            out_filtered,
  output logic [bmfc_pkg::BLK_W-1:0]                   out_index,
  output logic                                         out_last_of_block
);
  import bmfc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [BLK_W-1:0] blk_len_r;
  logic [KER_W-1:0] ker_len_r;
  logic [BLK_W-1:0] eff_blk;
  logic [KER_W-1:0] eff_ker;

  logic [1:0]       state_r;
  logic [TAP_W-1:0] wp_r;
  logic [BLK_W-1:0] pos_r;
  logic [TAP_W-1:0] j_r;
  logic [TAP_W-1:0] k_r;
  logic [KER_W-1:0] kl_r;
  logic             last_r;

  logic signed [SAMPLE_BITS-1:0] tmem [MAX_KERNEL];
  logic signed [SAMPLE_BITS-1:0] hmem [MAX_KERNEL];
  logic [MAX_KERNEL-1:0]         tval_r;
  logic [MAX_KERNEL-1:0]         hval_r;

  logic signed [SAMPLE_BITS-1:0] h_q;
  logic signed [SAMPLE_BITS-1:0] t_q;
  logic                          hv_q;
  logic                          tv_q;
  logic                          rd_v_r;
  logic signed [SAMPLE_BITS-1:0] op_h;
  logic signed [SAMPLE_BITS-1:0] op_t;
  logic signed [PROD_W-1:0]      p_r;
  logic                          prod_v_r;
  logic signed [ACC_W-1:0]       acc_r;

  logic             pop_coef;
  logic             pop_samp;
  logic             issue;
  logic             emit;
  logic             out_last;
  logic             done;
  logic [TAP_W-1:0] wp_next;
  logic [TAP_W-1:0] h_addr;
  logic [KER_W-1:0] kl_m1;

  always_comb begin
    if (blk_len_r == '0) begin
      eff_blk = BLK_W'(1);
    end else if (blk_len_r > BLK_W'(MAX_BLOCK)) begin
      eff_blk = BLK_W'(MAX_BLOCK);
    end else begin
      eff_blk = blk_len_r;
    end
    if (ker_len_r == '0) begin
      eff_ker = KER_W'(1);
    end else if (ker_len_r > KER_W'(MAX_KERNEL)) begin
      eff_ker = KER_W'(MAX_KERNEL);
    end else begin
      eff_ker = ker_len_r;
    end
  end

  assign pop      = (state_r == ST_IDLE) && head.valid;
  assign pop_coef = pop && !head.item.is_sample;
  assign pop_samp = pop && head.item.is_sample;
  assign issue    = (state_r == ST_ISSUE);
  assign wp_next  = wp_r + TAP_W'(1);
  assign h_addr   = wp_r - (k_r - j_r);
  assign kl_m1    = kl_r - KER_W'(1);
  assign emit     = (state_r == ST_DRAIN) && !rd_v_r && !prod_v_r &&
                    (!out_valid || out_ready);
  assign out_last = last_r && ({1'b0, j_r} == kl_m1);
  assign done     = !last_r || ({1'b0, j_r} == kl_m1);
  assign op_h     = hv_q ? h_q : '0;
  assign op_t     = tv_q ? t_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_len_r <= BLOCK_LENGTH_RST;
      ker_len_r <= KERNEL_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_LENGTH:  blk_len_r <= cfg_data[BLK_W-1:0];
        REG_KERNEL_LENGTH: ker_len_r <= cfg_data[KER_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop_coef) begin
      tmem[head.item.idx] <= head.item.value;
    end
    if (pop_samp) begin
      hmem[wp_next] <= head.item.value;
    end
    h_q  <= hmem[h_addr];
    t_q  <= tmem[k_r];
    hv_q <= hval_r[h_addr];
    tv_q <= tval_r[k_r];
    p_r  <= op_h * op_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tval_r <= '0;
      hval_r <= '0;
    end else begin
      if (pop_coef) begin
        tval_r[head.item.idx] <= 1'b1;
      end
      if (pop_samp) begin
        hval_r[wp_next] <= 1'b1;
      end else if (emit && done && last_r) begin
        hval_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wp_r     <= '0;
      pos_r    <= '0;
      j_r      <= '0;
      k_r      <= '0;
      kl_r     <= KER_W'(1);
      last_r   <= 1'b0;
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      if (prod_v_r) begin
        acc_r <= acc_r + {{(ACC_W-PROD_W){p_r[PROD_W-1]}}, p_r};
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop_samp) begin
            wp_r    <= wp_next;
            last_r  <= ({1'b0, pos_r} + (BLK_W+1)'(1)) >= {1'b0, eff_blk};
            kl_r    <= eff_ker;
            j_r     <= '0;
            k_r     <= '0;
            acc_r   <= '0;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if ({1'b0, k_r} == kl_m1) begin
            state_r <= ST_DRAIN;
          end else begin
            k_r <= k_r + TAP_W'(1);
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            if (done) begin
              state_r <= ST_IDLE;
              if (last_r) begin
                pos_r <= '0;
              end else begin
                pos_r <= pos_r + BLK_W'(1);
              end
            end else begin
              j_r     <= j_r + TAP_W'(1);
              k_r     <= j_r + TAP_W'(1);
              acc_r   <= '0;
              state_r <= ST_ISSUE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_filtered      <= acc_r;
      out_index         <= pos_r + BLK_W'(j_r);
      out_last_of_block <= out_last;
    end
  end

endmodule

`default_nettype wire

// File: src/block_matched_filter_convolver.sv
// ----------------------------------------------------------------------------
// Block matched-filter convolver
// The input channel carries coefficient writes (in_kind 0) and signal samples
// (in_kind 1). Each sample yields one exact Q8.30 convolution output on the
// result channel; the sample that ends a block also yields the tail outputs
// of the block, the final one flagged by out_last_of_block.
// Accepted items enter a four-entry queue; the back end takes one item at a
// time. Each output is summed tap by tap in the single multiply-accumulate
// unit, which reads the operands, registers their product and then
// accumulates it; a block-ending sample also walks its tail outputs, each
// over fewer taps, through the same unit.
// Reset clears the registers, the queue and the store valid bits, so both
// stores read as zero; no clearing pass is needed.
// When the receiver stalls the output register holds its result, the back end
// waits, and the queue keeps accepting until it is full.
// Configuration writes are taken in the cycle cfg_we is high.
// ----------------------------------------------------------------------------
`default_nettype none

module block_matched_filter_convolver (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cfg_we,
  input  wire logic [bmfc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [bmfc_pkg::CFG_W-1:0]              cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic                                    in_kind,
  input  wire logic [bmfc_pkg::TAP_W-1:0]              in_coef_index,
  input  wire logic signed [bmfc_pkg::SAMPLE_BITS-1:0] in_value,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [bmfc_pkg::ACC_W-1:0]            out_filtered,
  output logic [bmfc_pkg::BLK_W-1:0]                   out_index,
  output logic                                         out_last_of_block
);
  import bmfc_pkg::*;

  queue_head_t head;
  logic        pop;

  bmfc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_coef_index (in_coef_index),
    .in_value      (in_value),
    .head          (head),
    .pop           (pop)
  );

  bmfc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_filtered      (out_filtered),
    .out_index         (out_index),
    .out_last_of_block (out_last_of_block)
  );

endmodule

`default_nettype wire

// File: src/bmfc_checker.sv
// ----------------------------------------------------------------------------
// Block matched-filter convolver port checker
// Watches the top-level ports for reset behavior, result stability and the
// range of output positions.
// ----------------------------------------------------------------------------
`default_nettype none

module bmfc_checker (
  input wire logic                                    clk,
  input wire logic                                    rst_n,
  input wire logic                                    in_ready,
  input wire logic                                    out_valid,
  input wire logic                                    out_ready,
  input wire logic signed [bmfc_pkg::ACC_W-1:0]       out_filtered,
  input wire logic [bmfc_pkg::BLK_W-1:0]              out_index
);
  import bmfc_pkg::*;

  localparam logic [BLK_W-1:0] MAX_INDEX = BLK_W'(MAX_BLOCK + MAX_KERNEL - 2);

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_filtered) &&
      $stable(out_index))
    else $error("stalled result changed");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_index <= MAX_INDEX)
    else $error("output position beyond the longest block result");

endmodule

bind block_matched_filter_convolver bmfc_checker u_bmfc_checker (.*);

`default_nettype wire

// File: tb/bmfc_conv_checker.sv
// ----------------------------------------------------------------------------
// Block matched-filter convolver checker
// Watches the configuration port and both channels of the convolver. Every
// transfer on the input channel updates a local copy of the template, the
// sample history and the block position, and queues the convolution outputs
// that the transfer must produce. Every transfer on the result channel is
// compared field by field with the oldest queued output.
// ----------------------------------------------------------------------------
module bmfc_conv_checker
  import bmfc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_kind,
  input  logic [TAP_W-1:0]              in_coef_index,
  input  logic signed [SAMPLE_BITS-1:0] in_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [ACC_W-1:0]       out_filtered,
  input  logic [BLK_W-1:0]              out_index,
  input  logic                          out_last_of_block,
  output int                            mismatches,
  output int                            outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [ACC_W-1:0] filtered;
    logic [BLK_W-1:0]        index;
    logic                    last;
  } conv_out_t;

  logic signed [SAMPLE_BITS-1:0] history [MAX_KERNEL];
  logic signed [SAMPLE_BITS-1:0] template_taps [MAX_KERNEL];
  logic [BLK_W-1:0]              block_pos;
  logic [BLK_W-1:0]              block_len;
  logic [KER_W-1:0]              kernel_len;
  conv_out_t                     pending_outputs [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic convolve_sample(input logic signed [SAMPLE_BITS-1:0] sample);
    int        eff_block;
    int        eff_kernel;
    int        t;
    int        j;
    longint    acc;
    logic      block_done;
    conv_out_t result;
    eff_block  = (block_len < 1) ? 1 :
                 ((block_len > MAX_BLOCK) ? MAX_BLOCK : int'(block_len));
    eff_kernel = (kernel_len < 1) ? 1 :
                 ((kernel_len > MAX_KERNEL) ? MAX_KERNEL : int'(kernel_len));
    for (t = MAX_KERNEL - 1; t > 0; t--) history[t] = history[t-1];
    history[0] = sample;
    block_done = (int'(block_pos) + 1 >= eff_block);

    acc = 0;
    for (t = 0; t < eff_kernel; t++)
      acc += longint'(history[t]) * longint'(template_taps[t]);
    result.filtered = ACC_W'(acc);
    result.index    = block_pos;
    result.last     = block_done && (eff_kernel == 1);
    pending_outputs.push_back(result);

    if (!block_done) begin
      block_pos = block_pos + BLK_W'(1);
    end else begin
      // The tail outputs drain the kernel past the last sample of the block.
      for (j = 1; j < eff_kernel; j++) begin
        acc = 0;
        for (t = j; t < eff_kernel; t++)
          acc += longint'(history[t-j]) * longint'(template_taps[t]);
        result.filtered = ACC_W'(acc);
        result.index    = BLK_W'(int'(block_pos) + j);
        result.last     = (j == eff_kernel - 1);
        pending_outputs.push_back(result);
      end
      history   = '{default: '0};
      block_pos = '0;
    end
  endtask

  always @(posedge clk) begin
    conv_out_t want;
    if (!rst_n) begin
      history       = '{default: '0};
      template_taps = '{default: '0};
      block_pos     = '0;
      block_len     = BLOCK_LENGTH_RST;
      kernel_len    = KERNEL_LENGTH_RST;
      pending_outputs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BLOCK_LENGTH) begin
          block_len = cfg_data[BLK_W-1:0];
        end else if (cfg_index == REG_KERNEL_LENGTH) begin
          kernel_len = cfg_data[KER_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_COEF) begin
          template_taps[in_coef_index] = in_value;
        end else begin
          convolve_sample(in_value);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_outputs.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, %s %0d index %0d last %0b",
                   $time, "actual filtered", out_filtered, out_index, out_last_of_block);
          mismatches++;
        end else begin
          want = pending_outputs.pop_front();
          if (out_filtered !== want.filtered) begin
            $display("%0t: filtered at index %0d: expected %0d, actual %0d",
                     $time, want.index, want.filtered, out_filtered);
            mismatches++;
          end
          if (out_index !== want.index) begin
            $display("%0t: out_index: expected %0d, actual %0d", $time, want.index, out_index);
            mismatches++;
          end
          if (out_last_of_block !== want.last) begin
            $display("%0t: last_of_block at index %0d: expected %0b, actual %0b",
                     $time, want.index, want.last, out_last_of_block);
            mismatches++;
          end
        end
      end
    end
    outstanding = pending_outputs.size();
  end

endmodule

// File: tb/tb_block_matched_filter_convolver.sv
// ----------------------------------------------------------------------------
// Block matched-filter convolver testbench
// Drives coefficient writes and signal samples into the convolver, first a
// short directed sequence over the extremes and corner cases, then phases of
// random register settings, sine templates and sample streams. Both channels
// idle in random bursts except near the end. A separate checker predicts and
// compares every output; this module only drives stimulus and gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_block_matched_filter_convolver;

  timeunit 1ns;
  timeprecision 1ps;

  import bmfc_pkg::*;

  localparam int  TOTAL_ITEMS  = 470;
  localparam int  SETTLE_CYCLES = 100;
  localparam int  TAIL_CYCLES  = 3000;
  localparam int  CYCLE_LIMIT  = 5_000_000;
  localparam real PI           = 3.14159265358979;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]              cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_kind;
  logic [TAP_W-1:0]              in_coef_index;
  logic signed [SAMPLE_BITS-1:0] in_value;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [ACC_W-1:0]       out_filtered;
  logic [BLK_W-1:0]              out_index;
  logic                          out_last_of_block;
  int                            mismatches;
  int                            outstanding;
  int                            cycle_count = 0;
  int                            items_sent = 0;
  bit                            idling = 1'b1;

  block_matched_filter_convolver i_dut (.*);

  bmfc_conv_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Returns at the rising edge of the transfer.
  task automatic send_item(input logic kind, input logic [TAP_W-1:0] coef_idx,
                           input logic signed [SAMPLE_BITS-1:0] val);
    idling = (items_sent < TOTAL_ITEMS - 80);
    @(negedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_coef_index <= coef_idx;
    in_value      <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Coefficient writes still queued inside the block give no output, so a
  // short settle follows the last expected output.
  task automatic wait_for_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [BLK_W-1:0] blk;
    logic [KER_W-1:0] ker;
    int               taps;
    int               burst;
    real              amp;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_kind       = KIND_SAMPLE;
    in_coef_index = '0;
    in_value      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset lengths; the template is still all zero for the first sample.
    send_item(KIND_SAMPLE, 6'd21, 16'sh7FFF);
    send_item(KIND_COEF, 6'd0, 16'sh8000);
    send_item(KIND_SAMPLE, 6'd0, 16'sh8000);
    send_item(KIND_COEF, 6'd63, 16'sh8000);
    send_item(KIND_COEF, 6'd1, 16'sh7FFF);
    send_item(KIND_COEF, 6'd62, 16'sh7FFF);
    send_item(KIND_SAMPLE, 6'd42, 16'sh8000);
    send_item(KIND_SAMPLE, 6'd0, 16'sh7FFF);
    send_item(KIND_SAMPLE, 6'd0, 16'sh0000);
    send_item(KIND_SAMPLE, 6'd0, 16'shFFFF);
    // The position is already past the new block length, so the next sample
    // ends the block and drains a full-length tail.
    wait_for_quiet();
    write_reg(REG_BLOCK_LENGTH, 12'd3);
    send_item(KIND_SAMPLE, 6'd0, 16'sh8000);
    wait_for_quiet();
    write_reg(REG_BLOCK_LENGTH, 12'd1);
    write_reg(REG_KERNEL_LENGTH, 12'd0);
    send_item(KIND_SAMPLE, 6'd0, 16'sh8000);
    send_item(KIND_SAMPLE, 6'd0, 16'sh7FFF);
    wait_for_quiet();
    write_reg(REG_BLOCK_LENGTH, 12'd0);
    send_item(KIND_SAMPLE, 6'd0, 16'sh8000);
    wait_for_quiet();
    write_reg(REG_KERNEL_LENGTH, 12'hFFF);
    write_reg(REG_BLOCK_LENGTH, 12'hFFF);
    send_item(KIND_SAMPLE, 6'd0, 16'sh7FFF);
    send_item(KIND_SAMPLE, 6'd0, 16'sh8000);
    wait_for_quiet();
    write_reg(REG_BLOCK_LENGTH, 12'd2);
    send_item(KIND_SAMPLE, 6'd0, 16'sh7FFF);

    while (items_sent < TOTAL_ITEMS) begin
      wait_for_quiet();
      case ($urandom_range(0, 7))
        0:       blk = 12'd0;
        1:       blk = 12'd1;
        2:       blk = 12'd2;
        3:       blk = BLK_W'($urandom_range(3, 12));
        4:       blk = BLK_W'($urandom_range(13, 80));
        5:       blk = BLOCK_LENGTH_RST;
        6:       blk = BLK_W'($urandom_range(MAX_BLOCK + 1, 4095));
        default: blk = BLK_W'($urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 6))
        0:       ker = 7'd0;
        1:       ker = 7'd1;
        2:       ker = KERNEL_LENGTH_RST;
        3:       ker = KER_W'($urandom_range(MAX_KERNEL + 1, 127));
        default: ker = KER_W'($urandom_range(2, MAX_KERNEL - 1));
      endcase
      write_reg(REG_BLOCK_LENGTH, blk);
      write_reg(REG_KERNEL_LENGTH, {5'($urandom), ker});
      taps = (ker == 0) ? 1 : ((ker > MAX_KERNEL) ? MAX_KERNEL : int'(ker));

      // Most phases load a fresh half-sine pulse template.
      if (items_sent + taps <= TOTAL_ITEMS && $urandom_range(0, 3) != 0) begin
        amp = real'($urandom_range(1000, 32767));
        if ($urandom_range(0, 1) == 1) amp = -amp;
        for (int i = 0; i < taps; i++)
          send_item(KIND_COEF, TAP_W'(i),
                    SAMPLE_BITS'($rtoi(amp * $sin(PI * (real'(i) + 0.5) / real'(taps)))));
      end

      burst = $urandom_range(15, 45);
      while (burst > 0 && items_sent < TOTAL_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(KIND_COEF, TAP_W'($urandom), pick_value());
        end else begin
          send_item(KIND_SAMPLE, TAP_W'($urandom), pick_value());
        end
        burst--;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
